// ----- hw/rtl/dsw_pkg.sv -----
// Shared constants, types and state codes for the dice sum ways counter.
package dsw_pkg;

  // Width of one count and the prime that all counts are reduced by.
  localparam int WAY_W = 30;
  localparam logic [WAY_W-1:0] WAYS_PRIME = 30'd1000000007;

  // Saturation limits for the query fields and the default largest target sum.
  localparam int MAX_DICE = 32;
  localparam int MAX_FACES = 32;
  localparam int DEF_MAX_SUM = 1023;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIE,
    ST_READ,
    ST_ADD,
    ST_SUB,
    ST_FIN
  } dsw_state_t;

  // One request to the shared modular add/subtract unit.
  typedef struct packed {
    logic [WAY_W-1:0] acc;
    logic [WAY_W-1:0] opd;
    logic             sub;
  } dsw_mod_req_t;

endpackage

// ----- hw/rtl/dice_sum_ways_counter_core.sv -----
// Dice sum ways counter: top level with the row sequencer and two count banks.
//
// A query beat on the input channel carries dice_count, face_count and
// target_sum. The block answers with one way_count beat: the number of
// ordered rolls that reach target_sum, modulo 1000000007. Dice and faces
// saturate at 32; a target above MAX_SUM answers zero.
// in_ready is high only while the sequencer is idle; one query is worked
// on at a time. Two banks of counts take turns as previous and current row.
// With at least one die and a nonzero target, ST_INIT writes the first row
// up to the target; then for each die ST_DIE writes sum zero of the new row
// and each sum goes through ST_READ (read the previous row), ST_ADD (add the
// entering entry) and ST_SUB (remove the leaving one), the last two through
// the shared modular add/subtract unit.
// Trivial queries (no dice, zero target, target out of range) go straight to ST_FIN.
// The result sits in an output register; the next query is accepted while
// it waits. While the receiver stalls, a second finished result waits in ST_FIN.
// Reset clears the sequencer and the output valid; the banks keep no reset.
module dice_sum_ways_counter_core #(
  parameter int MAX_SUM = dsw_pkg::DEF_MAX_SUM
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [5:0]                dice_count,
  input  logic [5:0]                face_count,
  input  logic [9:0]                target_sum,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [dsw_pkg::WAY_W-1:0] way_count
);
  import dsw_pkg::*;

  localparam int DEPTH = MAX_SUM + 1;
  localparam int AW = $clog2(DEPTH);

  dsw_state_t state, state_next;

  logic [5:0]       dice, dice_next;
  logic [5:0]       faces, faces_next;
  logic [AW-1:0]    tgt, tgt_next;
  logic [AW-1:0]    s, s_next;
  logic [5:0]       die, die_next;
  logic             sel, sel_next;
  logic [WAY_W-1:0] window, window_next;
  logic [WAY_W-1:0] res, res_next;

  logic [5:0]       dice_sat;
  logic [5:0]       faces_sat;
  logic             tgt_bad;

  logic             we;
  logic             wbank;
  logic [AW-1:0]    waddr;
  logic [WAY_W-1:0] wdata;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [WAY_W-1:0] b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
  logic [WAY_W-1:0] rd_a, rd_b;
  logic             use_sub;

  dsw_mod_req_t     mreq;
  logic [WAY_W-1:0] mres;

  // Two count banks; sel names the one holding the previous row.
  dsw_ram #(.WIDTH(WAY_W), .DEPTH(DEPTH)) u_bank0 (
    .clk(clk), .we(we && !wbank), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(b0_rd_a), .rdata_b(b0_rd_b)
  );

  dsw_ram #(.WIDTH(WAY_W), .DEPTH(DEPTH)) u_bank1 (
    .clk(clk), .we(we && wbank), .waddr(waddr), .wdata(wdata),
    .raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(b1_rd_a), .rdata_b(b1_rd_b)
  );

  dsw_modunit u_mod (
    .req(mreq),
    .res(mres)
  );

  // The window enters sum s-1 and drops sum s-1-faces of the previous row.
  assign raddr_a = s - AW'(1);
  assign raddr_b = AW'(32'(s) - 32'(faces) - 32'd1);
  assign use_sub = 32'(s) > 32'(faces);
  assign rd_a    = sel ? b1_rd_a : b0_rd_a;
  assign rd_b    = sel ? b1_rd_b : b0_rd_b;

  // Query field saturation and range check.
  assign dice_sat  = (32'(dice_count) > MAX_DICE) ? 6'(MAX_DICE) : dice_count;
  assign faces_sat = (32'(face_count) > MAX_FACES) ? 6'(MAX_FACES) : face_count;
  assign tgt_bad   = 32'(target_sum) > 32'(MAX_SUM);

  assign in_ready = (state == ST_IDLE);

  // Sequencer state and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    dice   <= dice_next;
    faces  <= faces_next;
    tgt    <= tgt_next;
    s      <= s_next;
    die    <= die_next;
    sel    <= sel_next;
    window <= window_next;
    res    <= res_next;
  end

  // Next state, bank writes and unit requests.
  always_comb begin
    state_next  = state;
    dice_next   = dice;
    faces_next  = faces;
    tgt_next    = tgt;
    s_next      = s;
    die_next    = die;
    sel_next    = sel;
    window_next = window;
    res_next    = res;
    we          = 1'b0;
    wbank       = !sel;
    waddr       = s;
    wdata       = window;
    mreq.acc    = window;
    mreq.opd    = rd_a;
    mreq.sub    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          dice_next  = dice_sat;
          faces_next = faces_sat;
          tgt_next   = AW'(target_sum);
          s_next     = '0;
          sel_next   = 1'b0;
          if (tgt_bad) begin
            res_next   = '0;
            state_next = ST_FIN;
          end else if (dice_sat == 6'd0) begin
            res_next   = WAY_W'(target_sum == 10'd0);
            state_next = ST_FIN;
          end else if (target_sum == 10'd0) begin
            res_next   = '0;
            state_next = ST_FIN;
          end else begin
            state_next = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        // First row: one at sum zero, zero elsewhere up to the target.
        we    = 1'b1;
        wbank = sel;
        wdata = WAY_W'(s == '0);
        if (s == tgt) begin
          die_next   = 6'd1;
          state_next = ST_DIE;
        end else begin
          s_next = s + AW'(1);
        end
      end
      ST_DIE: begin
        // Sum zero of the new row is always zero.
        we          = 1'b1;
        waddr       = '0;
        wdata       = '0;
        window_next = '0;
        s_next      = AW'(1);
        state_next  = ST_READ;
      end
      ST_READ: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        window_next = mres;
        state_next  = ST_SUB;
      end
      ST_SUB: begin
        mreq.opd    = rd_b;
        mreq.sub    = 1'b1;
        window_next = use_sub ? mres : window;
        we          = 1'b1;
        wdata       = window_next;
        if (s == tgt) begin
          if (die == dice) begin
            res_next   = window_next;
            state_next = ST_FIN;
          end else begin
            die_next   = die + 6'd1;
            sel_next   = !sel;
            state_next = ST_DIE;
          end
        end else begin
          s_next     = s + AW'(1);
          state_next = ST_READ;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register; loaded when the finished result finds it free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      way_count <= res;
    end
  end

endmodule

// ----- hw/rtl/dsw_ram.sv -----
// Generic RAM with one write port and two registered read ports.
module dsw_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports are registered.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hw/rtl/dsw_modunit.sv -----
// Shared modular add/subtract unit for operands already below the prime.
module dsw_modunit (
  input  dsw_pkg::dsw_mod_req_t   req,
  output logic [dsw_pkg::WAY_W-1:0] res
);
  import dsw_pkg::*;

  logic [WAY_W:0] sum;
  logic [WAY_W:0] diff;

  // One add or subtract, then a single correction by the prime.
  always_comb begin
    sum  = {1'b0, req.acc} + {1'b0, req.opd};
    diff = {1'b0, req.acc} - {1'b0, req.opd};
    if (req.sub) begin
      if (diff[WAY_W]) begin
        res = WAY_W'(diff + {1'b0, WAYS_PRIME});
      end else begin
        res = diff[WAY_W-1:0];
      end
    end else begin
      if (sum >= {1'b0, WAYS_PRIME}) begin
        res = WAY_W'(sum - {1'b0, WAYS_PRIME});
      end else begin
        res = sum[WAY_W-1:0];
      end
    end
  end

endmodule

// ----- hw/rtl/dsw_checker.sv -----
// Port-level checker for the dice sum ways counter, bound to the top level.
module dsw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [dsw_pkg::WAY_W-1:0] way_count
);
  import dsw_pkg::*;

  // A query beat always drops in_ready right after it is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high right after a query beat");

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(way_count))
    else $error("result beat changed or vanished while stalled");

  // Every delivered count is reduced below the prime.
  a_out_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> way_count < WAYS_PRIME)
    else $error("way_count not reduced by the prime");

  // Reset leaves no result pending and the block ready.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("reset left a result pending or the block busy");

endmodule

bind dice_sum_ways_counter_core dsw_checker u_dsw_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .way_count(way_count)
);

// ----- test/tb_dice_sum_ways_counter_core.sv -----
// Self-checking testbench for the dice sum ways counter core.
module tb_dice_sum_ways_counter_core;
  import dsw_pkg::*;

  localparam int ROW_MAX = DEF_MAX_SUM;
  localparam int RANDOM_QUERIES = 81;
  localparam int CALM_QUERIES = 30;
  localparam int WATCHDOG_LIMIT = 500000;
  localparam int TAIL_CYCLES = 20;
  localparam longint unsigned PRIME_WIDE = longint'(WAYS_PRIME);

  // One directed query; the answer is typed in only where it is obvious.
  typedef struct packed {
    logic [5:0]       dice;
    logic [5:0]       faces;
    logic [9:0]       target;
    logic             known;
    logic [WAY_W-1:0] ways;
  } query_row_t;

  // One answer waiting to come out of the block.
  typedef struct packed {
    logic [5:0]       dice;
    logic [5:0]       faces;
    logic [9:0]       target;
    logic [WAY_W-1:0] ways;
  } pending_ways_t;

  localparam int DIRECTED_COUNT = 19;
  localparam query_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{6'd0,  6'd0,  10'd0,    1'b1, 30'd1},  // no dice, target zero
    '{6'd0,  6'd6,  10'd5,    1'b1, 30'd0},  // no dice, nonzero target
    '{6'd0,  6'd63, 10'd1023, 1'b1, 30'd0},  // no dice, largest target
    '{6'd3,  6'd6,  10'd0,    1'b1, 30'd0},  // target zero with dice
    '{6'd2,  6'd0,  10'd2,    1'b1, 30'd0},  // no faces
    '{6'd1,  6'd6,  10'd3,    1'b1, 30'd1},
    '{6'd2,  6'd6,  10'd7,    1'b1, 30'd6},
    '{6'd2,  6'd6,  10'd12,   1'b1, 30'd1},
    '{6'd2,  6'd6,  10'd13,   1'b1, 30'd0},
    '{6'd40, 6'd1,  10'd32,   1'b1, 30'd1},  // dice saturate to 32
    '{6'd1,  6'd63, 10'd32,   1'b1, 30'd1},  // faces saturate to 32
    '{6'd1,  6'd63, 10'd33,   1'b1, 30'd0},  // saturated faces cannot reach 33
    '{6'd1,  6'd32, 10'd1023, 1'b1, 30'd0},
    '{6'd10, 6'd6,  10'd35,   1'b0, 30'd0},
    '{6'd5,  6'd32, 10'd80,   1'b0, 30'd0},
    '{6'd20, 6'd20, 10'd210,  1'b0, 30'd0},
    '{6'd32, 6'd32, 10'd600,  1'b0, 30'd0},
    '{6'd32, 6'd32, 10'd1023, 1'b0, 30'd0},
    '{6'd63, 6'd63, 10'd1023, 1'b1, 30'd32}  // one die shows 31, the rest 32
  };

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [5:0]       dice_count;
  logic [5:0]       face_count;
  logic [9:0]       target_sum;
  logic             out_valid;
  logic             out_ready;
  logic [WAY_W-1:0] way_count;

  // Predictor rows, kept apart from the block's own banks.
  logic [WAY_W-1:0] prior_counts [0:ROW_MAX];
  logic [WAY_W-1:0] fresh_counts [0:ROW_MAX];

  pending_ways_t    pending_ways [$];
  logic             drv_known;
  logic [WAY_W-1:0] drv_ways;
  bit               stall_enable;
  int               error_count;
  int               checked_count;
  int               query_count;
  int               idle_cycles;

  dice_sum_ways_counter_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dice_count (dice_count),
    .face_count (face_count),
    .target_sum (target_sum),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .way_count  (way_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Row-by-row count of ordered rolls, reduced by the prime.
  function automatic logic [WAY_W-1:0] count_ways(input logic [5:0] dice_in,
                                                  input logic [5:0] faces_in,
                                                  input logic [9:0] target_in);
    int dice;
    int faces;
    int target;
    int die;
    int s;
    longint unsigned window;
    dice = (dice_in > MAX_DICE) ? MAX_DICE : int'(dice_in);
    faces = (faces_in > MAX_FACES) ? MAX_FACES : int'(faces_in);
    target = int'(target_in);
    if (target > ROW_MAX) return '0;
    for (s = 0; s <= target; s++) prior_counts[s] = '0;
    prior_counts[0] = WAY_W'(1);
    for (die = 1; die <= dice; die++) begin
      window = 0;
      fresh_counts[0] = '0;
      // The window spans the previous row from s-faces to s-1.
      for (s = 1; s <= target; s++) begin
        window = (window + prior_counts[s-1]) % PRIME_WIDE;
        if (s > faces) begin
          window = (window + PRIME_WIDE - prior_counts[s-1-faces]) % PRIME_WIDE;
        end
        fresh_counts[s] = window[WAY_W-1:0];
      end
      for (s = 0; s <= target; s++) prior_counts[s] = fresh_counts[s];
    end
    return prior_counts[target];
  endfunction

  task automatic report_mismatch(input string what, input pending_ways_t want,
                                 input logic [WAY_W-1:0] got);
    $display("MISMATCH %s: dice=%0d faces=%0d target=%0d expected=%0d got=%0d",
             what, want.dice, want.faces, want.target, want.ways, got);
    error_count++;
  endtask

  // Present one query beat and hold it until the block takes it.
  task automatic send_query(input logic [5:0] dice, input logic [5:0] faces,
                            input logic [9:0] target, input logic known,
                            input logic [WAY_W-1:0] ways);
    while (stall_enable && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    dice_count <= dice;
    face_count <= faces;
    target_sum <= target;
    drv_known = known;
    drv_ways = ways;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    query_count++;
    @(negedge clk);
  endtask

  // Receiver side: random back-pressure on the result channel while stalls are enabled.
  always @(negedge clk) begin
    out_ready <= stall_enable ? ($urandom_range(0, 99) >= 32) : 1'b1;
  end

  // Sample both channels, predict on query beats, check on result beats.
  always @(posedge clk) begin
    pending_ways_t want;
    pending_ways_t got_entry;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_entry = '0;
        got_entry.ways = way_count;
        if (pending_ways.size() == 0) begin
          report_mismatch("result with nothing pending", got_entry, way_count);
        end else begin
          want = pending_ways.pop_front();
          checked_count++;
          if (way_count !== want.ways) report_mismatch("way_count", want, way_count);
        end
      end
      if (in_valid && in_ready) begin
        want.dice = dice_count;
        want.faces = face_count;
        want.target = target_sum;
        want.ways = drv_known ? drv_ways : count_ways(dice_count, face_count, target_sum);
        pending_ways.push_back(want);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop a hung run.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Timeout: no beat on either channel for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int i;
    int pick;
    logic [5:0] dice;
    logic [5:0] faces;
    logic [9:0] target;
    rst = 1'b1;
    in_valid = 1'b0;
    dice_count = '0;
    face_count = '0;
    target_sum = '0;
    out_ready = 1'b0;
    drv_known = 1'b0;
    drv_ways = '0;
    stall_enable = 1'b1;
    error_count = 0;
    checked_count = 0;
    query_count = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table: extremes, saturation and the trivial answers.
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      send_query(DIRECTED_ROWS[i].dice, DIRECTED_ROWS[i].faces, DIRECTED_ROWS[i].target,
                 DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].ways);
    end

    // Random queries, mostly small so the run stays short; the first stretch
    // runs with no stalls on either side.
    for (i = 0; i < RANDOM_QUERIES; i++) begin
      stall_enable = (i >= CALM_QUERIES);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        dice = 6'($urandom_range(0, 12));
        faces = 6'($urandom_range(1, 32));
        target = 10'($urandom_range(0, 48));
      end else if (pick < 88) begin
        dice = 6'($urandom_range(33, 63));
        faces = 6'($urandom_range(0, 63));
        target = 10'($urandom_range(0, 40));
      end else if (pick < 94) begin
        dice = 6'($urandom_range(0, 8));
        faces = 6'($urandom_range(0, 63));
        target = 10'($urandom_range(0, ROW_MAX));
      end else begin
        dice = 6'($urandom_range(0, 63));
        faces = 6'($urandom_range(0, 63));
        target = 10'($urandom_range(0, 63));
      end
      send_query(dice, faces, target, 1'b0, '0);
    end
    in_valid <= 1'b0;
    stall_enable = 1'b1;

    // Drain the remaining answers, then let the block settle.
    while (pending_ways.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_ways.size() != 0) begin
      $display("%0d answers never arrived", pending_ways.size());
      error_count++;
    end

    $display("Sent %0d queries (%0d directed, %0d random) and checked %0d answers.",
             query_count, DIRECTED_COUNT, RANDOM_QUERIES, checked_count);
    $display("Coverage: zero dice, zero faces and target, saturated fields, full-size rows.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dsw_pkg.sv
hw/rtl/dsw_ram.sv
hw/rtl/dsw_modunit.sv
hw/rtl/dice_sum_ways_counter_core.sv
hw/rtl/dsw_checker.sv
test/tb_dice_sum_ways_counter_core.sv
